FILE: src/uorc_pkg.sv
package uorc_pkg;

   localparam int ValueWidth  = 9;
   localparam int ActionWidth = 2;

   typedef logic [ValueWidth-1:0]  value_type;
   typedef logic [ActionWidth-1:0] action_type;

   // Item kinds carried on the request channel.
   localparam action_type ActStart   = 2'd0;
   localparam action_type ActLoad    = 2'd1;
   localparam action_type ActElement = 2'd2;
   localparam action_type ActFinish  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sweep_begin;   // start of a session: clear counters, restart the sweep
      logic sweep;         // write zero into both bitmaps at the sweep address
      logic load;          // take a permutation value
      logic elem_issue;    // issue step of an element: range check, memory reads
      logic elem_commit;   // commit step of an element: compare and mark
      logic capture;       // register the verdict
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_last;    // the sweep address points at the last bitmap entry
   } dp_status_type;

endpackage

FILE: src/unique_order_reconstruction_check.sv
// Unique-order reconstruction check.
//
// The request channel carries one beat per item. req_tuser selects the kind of
// beat (start, load, element, finish) and flags the first element of a
// subsequence; req_tdata carries the value. A start beat opens a session, load
// beats give the permutation one value at a time, element beats stream the
// subsequences, and a finish beat produces exactly one response beat whose
// rsp_tdata bit 0 is 1 when the subsequences fix the permutation uniquely.
//
// Timing: an element beat first does the position table and bitmap reads,
// then the compare and mark; load and finish beats are done when taken. The verdict is
// registered and appears on rsp_tvalid the cycle after the finish beat. A
// start beat is followed by a clearing pass over every entry of both bitmaps,
// during which req_tready is low. After reset the same pass runs first.
// When the receiver stalls, the verdict waits in its output register; load,
// element and start beats are still taken, and only a further finish beat is
// held off until the pending verdict is taken.
module unique_order_reconstruction_check #(
   parameter int MAX_LEN = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] value, rest zero
   input  logic [2:0]  req_tuser,   // [1:0] action, [2] first_of_sequence
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] verdict, rest zero
);

   uorc_pkg::dp_cmd_type    cmd;
   uorc_pkg::dp_status_type status;
   logic                    verdict;

   // The controller sequences each beat; the datapath holds the table,
   // bitmaps and session counters.
   uorc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser[1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   uorc_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .value             (req_tdata[8:0]),
      .first_of_sequence (req_tuser[2]),
      .status            (status),
      .verdict           (verdict)
   );

   assign rsp_tdata = {7'b0, verdict};

endmodule

FILE: src/uorc_dp.sv
module uorc_dp #(
   parameter int MAX_LEN = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  uorc_pkg::dp_cmd_type   cmd,
   input  uorc_pkg::value_type    value,
   input  logic                   first_of_sequence,
   output uorc_pkg::dp_status_type status,
   output logic                   verdict
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int CW = (LW > uorc_pkg::ValueWidth) ? LW : uorc_pkg::ValueWidth;
   localparam logic [CW-1:0] MaxLenC  = CW'(MAX_LEN);
   localparam logic [LW-1:0] MaxLenL  = LW'(MAX_LEN);
   localparam logic [AW-1:0] LastAddr = AW'(MAX_LEN - 1);

   logic [AW-1:0] pos_mem  [MAX_LEN];
   logic          seen_mem [MAX_LEN];
   logic          adj_mem  [MAX_LEN];

   logic [LW-1:0] loaded_ff, loaded_in;
   logic [LW-1:0] seen_total_ff, seen_total_in;
   logic [LW-1:0] adj_total_ff, adj_total_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic          failed_ff, failed_in;
   logic          any_ff, any_in;
   logic [AW-1:0] sweep_addr_ff, sweep_addr_in;
   logic          in_range_ff, cont_ff;
   logic [AW-1:0] idx_ff;
   logic [AW-1:0] pos_rd_ff;
   logic          seen_rd_ff, adj_rd_ff;
   logic          verdict_ff;

   logic [CW-1:0] value_c, idx_c;
   logic [AW-1:0] idx;
   logic          elem_in_range, load_in_range, load_full, load_write;
   logic          seen_set, adj_set, pos_behind, pos_next;
   logic          seen_we, adj_we;
   logic [AW-1:0] seen_wa, adj_wa;
   logic          verdict_calc;

   assign value_c       = CW'(value);
   assign idx_c         = value_c - CW'(1);
   assign idx           = idx_c[AW-1:0];
   assign elem_in_range = (value != '0) && (value_c <= CW'(loaded_ff));
   assign load_in_range = (value != '0) && (value_c <= MaxLenC);
   assign load_full     = (loaded_ff == MaxLenL);
   assign load_write    = cmd.load && !load_full && load_in_range;

   assign pos_behind = (pos_rd_ff <= prev_ff);
   assign pos_next   = ({1'b0, pos_rd_ff} == ({1'b0, prev_ff} + (AW + 1)'(1)));
   assign seen_set   = cmd.elem_commit && in_range_ff && !seen_rd_ff;
   assign adj_set    = cmd.elem_commit && in_range_ff && cont_ff && !pos_behind
                       && pos_next && !adj_rd_ff;

   assign seen_we = cmd.sweep || seen_set;
   assign adj_we  = cmd.sweep || adj_set;
   assign seen_wa = cmd.sweep ? sweep_addr_ff : idx_ff;
   assign adj_wa  = cmd.sweep ? sweep_addr_ff : prev_ff;

   // Empty permutation passes; else no failure, and every value seen and linked.
   assign verdict_calc = (loaded_ff == '0) ||
                         (any_ff && !failed_ff && (seen_total_ff == loaded_ff) &&
                          (adj_total_ff == (loaded_ff - LW'(1))));

   always_comb begin
      loaded_in     = loaded_ff;
      seen_total_in = seen_total_ff;
      adj_total_in  = adj_total_ff;
      prev_in       = prev_ff;
      failed_in     = failed_ff;
      any_in        = any_ff;
      sweep_addr_in = sweep_addr_ff;
      if (cmd.sweep_begin) begin
         loaded_in     = '0;
         seen_total_in = '0;
         adj_total_in  = '0;
         prev_in       = '0;
         failed_in     = 1'b0;
         any_in        = 1'b0;
         sweep_addr_in = '0;
      end
      if (cmd.sweep) begin
         sweep_addr_in = sweep_addr_ff + AW'(1);
      end
      if (cmd.load) begin
         if (load_full) begin
            failed_in = 1'b1;
         end else begin
            loaded_in = loaded_ff + LW'(1);
         end
      end
      if (cmd.elem_issue) begin
         any_in = 1'b1;
         if (!elem_in_range) begin
            failed_in = 1'b1;
         end
      end
      if (cmd.elem_commit && in_range_ff) begin
         prev_in = pos_rd_ff;
         if (cont_ff && pos_behind) begin
            failed_in = 1'b1;
         end
      end
      if (seen_set) begin
         seen_total_in = seen_total_ff + LW'(1);
      end
      if (adj_set) begin
         adj_total_in = adj_total_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= '0;
         seen_total_ff <= '0;
         adj_total_ff  <= '0;
         prev_ff       <= '0;
         failed_ff     <= 1'b0;
         any_ff        <= 1'b0;
         sweep_addr_ff <= '0;
      end else begin
         loaded_ff     <= loaded_in;
         seen_total_ff <= seen_total_in;
         adj_total_ff  <= adj_total_in;
         prev_ff       <= prev_in;
         failed_ff     <= failed_in;
         any_ff        <= any_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   // Per-element context held from the issue step to the commit step, and the verdict register.
   always_ff @(posedge clock) begin
      if (cmd.elem_issue) begin
         in_range_ff <= elem_in_range;
         cont_ff     <= !first_of_sequence && any_ff;
         idx_ff      <= idx;
      end
      if (cmd.capture) begin
         verdict_ff <= verdict_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (load_write) begin
         pos_mem[idx] <= loaded_ff[AW-1:0];
      end
      pos_rd_ff <= pos_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_wa] <= !cmd.sweep;
      end
      seen_rd_ff <= seen_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wa] <= !cmd.sweep;
      end
      adj_rd_ff <= adj_mem[prev_ff];
   end

   assign status.sweep_last = (sweep_addr_ff == LastAddr);
   assign verdict           = verdict_ff;

   a_session_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_begin |=> (loaded_ff == '0) && (seen_total_ff == '0) && (adj_total_ff == '0)
                          && !failed_ff && !any_ff)
      else $error("session counters not cleared on start");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_total_ff <= loaded_ff)
      else $error("more values seen than loaded");

   a_loaded_bounded: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= MaxLenL)
      else $error("loaded length beyond table depth");

endmodule

FILE: src/uorc_ctrl.sv
module uorc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  uorc_pkg::action_type    action,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output uorc_pkg::dp_cmd_type    cmd,
   input  uorc_pkg::dp_status_type status
);

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StClear = 2'd1;
   localparam logic [1:0] StElem  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   // Only a finish needs the output register; other beats pass a waiting result.
   assign req_tready = (state_ff == StIdle) &&
                       ((action != uorc_pkg::ActFinish) || out_free);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               unique case (action)
                  uorc_pkg::ActStart: begin
                     cmd.sweep_begin = 1'b1;
                     state_in        = StClear;
                  end
                  uorc_pkg::ActLoad: begin
                     cmd.load = 1'b1;
                  end
                  uorc_pkg::ActElement: begin
                     cmd.elem_issue = 1'b1;
                     state_in       = StElem;
                  end
                  default: begin
                     cmd.capture = 1'b1;
                  end
               endcase
            end
         end
         StClear: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = StIdle;
            end
         end
         StElem: begin
            cmd.elem_commit = 1'b1;
            state_in        = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   assign rsp_valid_in = cmd.capture ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StClear;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_elem_two_cycles: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StElem) |=> (state_ff == StIdle))
      else $error("element commit did not return to idle");

   a_start_sweeps: assert property (@(posedge clock) disable iff (reset)
      (accept && (action == uorc_pkg::ActStart)) |=> (state_ff == StClear) && !req_tready)
      else $error("start beat did not enter the clearing pass");

endmodule

FILE: sim/order_verdict_checker.sv
// Watches both channels of the unique-order reconstruction check. It keeps its
// own copy of the session state, works out the verdict for every finish beat,
// and compares the response beats against those verdicts in order.
module order_verdict_checker #(
   parameter int MaxLen = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] value, rest zero
   input  logic [2:0]  req_tuser,   // [1:0] action, [2] first_of_sequence
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [0] verdict, rest zero
   output int          mismatch_count,
   output int          verdicts_pending
);

   // The position table is never cleared; stimulus only reads entries written
   // since the last start.
   logic [7:0]        position_of [MaxLen];
   logic [MaxLen-1:0] seen_bits;
   logic [MaxLen-1:0] adjacent_bits;
   logic [8:0]        perm_length;
   logic [8:0]        seen_count;
   logic [8:0]        adjacent_count;
   logic [7:0]        last_position;
   logic              broken;
   logic              element_arrived;
   logic              verdict_queue [$];
   int                errors = 0;

   task automatic clear_session();
      seen_bits       = '0;
      adjacent_bits   = '0;
      perm_length     = '0;
      seen_count      = '0;
      adjacent_count  = '0;
      last_position   = '0;
      broken          = 1'b0;
      element_arrived = 1'b0;
   endtask

   task automatic take_load(input uorc_pkg::value_type val);
      if (perm_length >= MaxLen) begin
         broken = 1'b1;
      end else begin
         if (val >= 1 && val <= MaxLen) position_of[int'(val) - 1] = perm_length[7:0];
         perm_length++;
      end
   endtask

   task automatic take_element(input uorc_pkg::value_type val, input logic first);
      logic       continues;
      logic [7:0] pos;
      int         idx;
      continues       = !first && element_arrived;
      element_arrived = 1'b1;
      if (val == 0 || val > perm_length) begin
         broken = 1'b1;
      end else begin
         idx = int'(val) - 1;
         pos = position_of[idx];
         if (!seen_bits[idx]) begin
            seen_bits[idx] = 1'b1;
            seen_count++;
         end
         if (continues) begin
            if (pos <= last_position) begin
               broken = 1'b1;
            end else if ({1'b0, pos} == {1'b0, last_position} + 9'd1) begin
               if (!adjacent_bits[last_position]) begin
                  adjacent_bits[last_position] = 1'b1;
                  adjacent_count++;
               end
            end
         end
         last_position = pos;
      end
   endtask

   function automatic logic order_verdict();
      if (perm_length == 0) return 1'b1;
      if (!element_arrived || broken) return 1'b0;
      return (seen_count == perm_length) && (adjacent_count == perm_length - 9'd1);
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         clear_session();
         verdict_queue.delete();
      end else begin
         // A verdict taken at this edge can only belong to an earlier finish.
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected verdict beat, expected none, got %0b",
                        $time, rsp_tdata[0]);
               errors++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_tdata[0] !== want) begin
                  $display("%0t: verdict mismatch, expected %0b, got %0b",
                           $time, want, rsp_tdata[0]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (uorc_pkg::action_type'(req_tuser[1:0]))
               uorc_pkg::ActStart:   clear_session();
               uorc_pkg::ActLoad:    take_load(req_tdata[8:0]);
               uorc_pkg::ActElement: take_element(req_tdata[8:0], req_tuser[2]);
               default:              verdict_queue.push_back(order_verdict());
            endcase
         end
      end
      mismatch_count   <= errors;
      verdicts_pending <= verdict_queue.size();
   end

endmodule

FILE: sim/unique_order_reconstruction_check_test.sv
// Top of the testbench. It makes the clock and the single reset, drives the
// request channel and the response back-pressure, and gives the verdict. All
// prediction and comparison lives in the checker instantiated beside the block.
module unique_order_reconstruction_check_test;

   localparam int MaxLen        = 256;
   // Beats sent before the closing full-length session, which adds another
   // 2 * MaxLen + 4 beats on top.
   localparam int RandomItems   = 800 - (2 * MaxLen + 4);
   // Long receiver hold-off; longer than one clearing pass so the block has to
   // hold a verdict and then refuse the next finish beat.
   localparam int HoldCycles    = 400;
   // A hold-off plus a clearing pass is the longest quiet stretch of a good run.
   localparam int WatchdogLimit = 3000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;   // [8:0] value, rest zero
   logic [2:0]  req_tuser  = '0;   // [1:0] action, [2] first_of_sequence
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [7:0]  rsp_tdata;         // [0] verdict, rest zero

   int mismatch_count;
   int verdicts_pending;

   // Idle rates of the two sides, in percent, set per phase by the sender.
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   // Raised once by the sender; the receiver clears it after its long hold-off.
   logic hold_request   = 1'b0;

   // Stimulus bookkeeping: which values were loaded since the last start, and
   // how many load beats took a position. An element beat whose value lies in
   // 1..stim_length but was never loaded would read a stale table entry, so
   // such values are steered out of range before they are sent.
   logic [MaxLen:1] loaded_now  = '0;
   int              stim_length = 0;
   int              items_sent  = 0;

   unique_order_reconstruction_check #(
      .MAX_LEN(MaxLen)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   order_verdict_checker #(
      .MaxLen(MaxLen)
   ) verdict_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offers one request beat and returns at the edge where it was taken. The
   // valid is left high afterwards, so a following call can present its beat
   // in the same step without a dip; any caller that lets time pass between
   // beats must lower it first.
   task automatic send_beat(input uorc_pkg::action_type act, input uorc_pkg::value_type val,
                            input logic first);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      case (act)
         uorc_pkg::ActStart: begin
            loaded_now  = '0;
            stim_length = 0;
         end
         uorc_pkg::ActLoad: begin
            if (stim_length < MaxLen) begin
               if (val >= 1 && val <= MaxLen) loaded_now[val] = 1'b1;
               stim_length++;
            end
         end
         default: ;
      endcase
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, val};
      req_tuser  <= {first, act};
      items_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_element(input int val, input logic first);
      int legal_val;
      legal_val = val;
      if (legal_val >= 1 && legal_val <= stim_length && !loaded_now[legal_val])
         legal_val = stim_length + 1;
      send_beat(uorc_pkg::ActElement, uorc_pkg::value_type'(legal_val), first);
   endtask

   // Random beats of any kind, including starts; element values stay legal.
   task automatic send_noise(input int count);
      uorc_pkg::action_type act;
      for (int i = 0; i < count; i++) begin
         act = uorc_pkg::action_type'($urandom_range(3));
         if (act == uorc_pkg::ActElement)
            send_element($urandom_range(511), 1'($urandom_range(1)));
         else
            send_beat(act, uorc_pkg::value_type'($urandom_range(511)), 1'($urandom_range(1)));
      end
   endtask

   // Stops offering beats until every verdict already owed has been taken.
   task automatic drain_verdicts();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
   endtask

   task automatic apply_idle_phase(input int phase);
      case (phase)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 61;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 61;
         end
         default: begin
            send_idle_pct  = 28;
            recv_stall_pct = 28;
         end
      endcase
   endtask

   // One session: start, load a shuffled permutation of 1..n, stream
   // overlapping windows that cover every adjacency, then finish. Rare
   // corruptions (stray loads, dropped windows, stray or repeated elements,
   // noise beats) make the verdict fall the other way now and then.
   task automatic run_session(input int n);
      int order [$];
      int pos;
      int last;
      logic opened;
      send_beat(uorc_pkg::ActStart, uorc_pkg::value_type'($urandom_range(511)),
                1'($urandom_range(1)));
      for (int v = 1; v <= n; v++) order.push_back(v);
      order.shuffle();
      foreach (order[i]) begin
         if ($urandom_range(39) == 0)
            send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'($urandom_range(511)),
                      1'($urandom_range(1)));
         send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(order[i]), 1'($urandom_range(1)));
      end
      if (n > 0) begin
         pos = 0;
         do begin
            last = pos + $urandom_range(4, 1);
            if (last > n - 1) last = n - 1;
            if ($urandom_range(11) != 0) begin
               for (int i = pos; i <= last; i++) begin
                  // A window normally opens with the flag set; sometimes it
                  // continues the previous one instead.
                  if (i == pos) opened = ($urandom_range(9) != 0);
                  else opened = 1'b0;
                  if ($urandom_range(29) == 0) send_element($urandom_range(511), opened);
                  else send_element(order[i], opened);
                  if ($urandom_range(39) == 0) send_element(order[i], 1'b0);
                  if ($urandom_range(39) == 0) send_noise(1);
               end
            end
            pos = last;
         end while (pos < n - 1);
         // An extra subsequence over a random subset, in order.
         if ($urandom_range(2) == 0) begin
            opened = 1'b1;
            foreach (order[i]) begin
               if ($urandom_range(1) == 1) begin
                  send_element(order[i], opened);
                  opened = 1'b0;
               end
            end
         end
      end
      send_beat(uorc_pkg::ActFinish, uorc_pkg::value_type'($urandom_range(511)),
                1'($urandom_range(1)));
      if ($urandom_range(4) == 0)
         send_beat(uorc_pkg::ActFinish, uorc_pkg::value_type'($urandom_range(511)),
                   1'($urandom_range(1)));
   endtask

   // The longest permutation, covered by one subsequence, then one load beyond
   // the table size, which fails the session.
   task automatic run_full_session();
      int order [$];
      send_beat(uorc_pkg::ActStart, '0, 1'b0);
      for (int v = 1; v <= MaxLen; v++) order.push_back(v);
      order.shuffle();
      foreach (order[i]) send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(order[i]), 1'b0);
      foreach (order[i]) send_element(order[i], i == 0);
      send_beat(uorc_pkg::ActFinish, '0, 1'b0);
      send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'($urandom_range(511)), 1'b1);
      send_beat(uorc_pkg::ActFinish, '0, 1'b1);
   endtask

   // Receiver: random back-pressure at the rate of the phase, and one long
   // hold-off on request while the sender keeps offering beats.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: ends the run if neither channel moves a beat for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WatchdogLimit) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int session;
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A finish straight after reset and one right after a
      // start both see an empty permutation.
      send_beat(uorc_pkg::ActFinish, '0, 1'b0);
      send_beat(uorc_pkg::ActStart, uorc_pkg::value_type'(511), 1'b1);
      send_beat(uorc_pkg::ActFinish, '0, 1'b1);
      // Permutation 2 1 3 streamed as one run with the flag never set: the
      // first element after start counts as the opening of a subsequence.
      send_beat(uorc_pkg::ActStart, '0, 1'b0);
      send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(2), 1'b0);
      send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(1), 1'b1);
      send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(3), 1'b0);
      send_element(2, 1'b0);
      send_element(1, 1'b0);
      send_element(3, 1'b0);
      send_beat(uorc_pkg::ActFinish, '0, 1'b0);
      // An element of value zero is out of range and fails the session.
      send_element(0, 1'b1);
      send_beat(uorc_pkg::ActFinish, '0, 1'b0);
      // Loads of zero and of values past the table size take a position but
      // write nothing; the boundary values of the table go in too.
      send_beat(uorc_pkg::ActStart, '0, 1'b0);
      send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(0), 1'b0);
      send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(511), 1'b1);
      send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(256), 1'b0);
      send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(257), 1'b0);
      send_beat(uorc_pkg::ActLoad, uorc_pkg::value_type'(1), 1'b0);
      send_element(1, 1'b1);
      send_element(511, 1'b0);
      send_element(256, 1'b0);
      send_beat(uorc_pkg::ActFinish, uorc_pkg::value_type'(511), 1'b1);

      // Random part: mostly well-formed sessions with random content, the
      // idle pattern changing every few sessions.
      session = 0;
      while (items_sent < RandomItems) begin
         apply_idle_phase((session / 3) % 4);
         if (session == 2) begin
            // Back-to-back finish beats while the receiver holds off: the
            // second one must wait until the first verdict is taken.
            hold_request = 1'b1;
            send_beat(uorc_pkg::ActFinish, '0, 1'b0);
            send_beat(uorc_pkg::ActFinish, '0, 1'b1);
            send_beat(uorc_pkg::ActFinish, '0, 1'b0);
         end
         if (session == 4) drain_verdicts();
         if ($urandom_range(9) == 0) send_noise($urandom_range(6, 1));
         case ($urandom_range(15))
            0:       n = 0;
            1, 2:    n = $urandom_range(40, 11);
            default: n = $urandom_range(10, 1);
         endcase
         run_session(n);
         session++;
      end
      apply_idle_phase(3);
      run_full_session();

      drain_verdicts();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
